>>> src/udn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udn_pkg: shared types and constants for the url path decoder
// Request and result structs, mode codes, character codes, hex helpers.
// ----------------------------------------------------------------------------
package udn_pkg;

  localparam int BufDepth = 1024;
  localparam int AddrW    = 10;
  localparam int LenW     = 11;

  localparam logic [1:0] ModeByte   = 2'd0;
  localparam logic [1:0] ModeFinish = 2'd1;
  localparam logic [1:0] ModeRead   = 2'd2;
  localparam logic [1:0] ModeStart  = 2'd3;

  localparam logic [7:0] ChPct   = 8'h25;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChDot   = 8'h2E;
  localparam logic [7:0] CaseBit = 8'h20;

  localparam logic [LenW-1:0] CapReset = LenW'(BufDepth);

  typedef struct packed {
    logic [1:0]       mode;
    logic [7:0]       url_byte;
    logic [AddrW-1:0] read_index;
  } req_t;

  typedef struct packed {
    logic [LenW-1:0] path_length;
    logic [7:0]      read_data;
    logic            stopped;
  } rsp_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic [7:0] l;
    l = c | CaseBit;
    return (c >= 8'h30 && c <= 8'h39) || (l >= 8'h61 && l <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] l;
    l = (c | CaseBit) - 8'h57;
    if (c >= 8'h30 && c <= 8'h39) return c[3:0];
    return l[3:0];
  endfunction

endpackage

>>> src/url_path_decode_normalize.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_path_decode_normalize: percent decode and path normalisation
// Builds a normalised path in a byte ram, one url byte per request.
// ----------------------------------------------------------------------------
//  channel   | signals                  | direction
//  request   | start_i, busy_o, req_i   | in, busy_o out
//  result    | done_o, rsp_o            | out
//  config    | cfg_we_i, cfg_wdata_i    | in
//
// busy_o stays high from an accepted request through the done_o cycle; a url
// byte or a finish takes longer with the held escape bytes and the slash rules,
// and a '/../' walk back reads every byte it scans through the single ram port.
// After reset the SInit state writes '/' at position zero while busy_o is high.
// done_o is high for one cycle per request; the receiver cannot stall.
module url_path_decode_normalize (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  udn_pkg::req_t       req_i,
  output logic                done_o,
  output udn_pkg::rsp_t       rsp_o,
  input  logic                cfg_we_i,
  input  logic [udn_pkg::LenW-1:0] cfg_wdata_i
);

  localparam logic [3:0] SIdle = 4'd0;
  localparam logic [3:0] SInit = 4'd1;
  localparam logic [3:0] SNext = 4'd2;
  localparam logic [3:0] SE1   = 4'd3;
  localparam logic [3:0] SE2   = 4'd4;
  localparam logic [3:0] SE3   = 4'd5;
  localparam logic [3:0] SEw   = 4'd6;
  localparam logic [3:0] SF0   = 4'd7;
  localparam logic [3:0] SF1   = 4'd8;
  localparam logic [3:0] SF2   = 4'd9;
  localparam logic [3:0] SF3   = 4'd10;
  localparam logic [3:0] SWk   = 4'd11;
  localparam logic [3:0] SRd   = 4'd12;
  localparam logic [3:0] SDone = 4'd13;

  localparam int LW = udn_pkg::LenW;
  localparam int AW = udn_pkg::AddrW;

  logic [3:0]    state_q, state_d;
  logic [LW-1:0] wp_q, wp_d, p_q, p_d, cap_q;
  logic [1:0]    ph_q, ph_d, qcnt_q, qcnt_d;
  logic [7:0]    held_q, held_d, data_q, data_d;
  logic [7:0]    que_q [3];
  logic [7:0]    que_d [3];
  logic          stop_q, stop_d, fin_q, fin_d, wfin_q, wfin_d;

  logic          ram_en, ram_we;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata, ram_rdata;
  logic [LW-1:0] cap_lim, pm3;
  logic          accept;

  udn_ram #(.Width(8), .Depth(udn_pkg::BufDepth)) u_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign accept  = start_i && (state_q == SIdle);
  assign cap_lim = (cap_q > udn_pkg::CapReset) ? udn_pkg::CapReset : cap_q;
  assign pm3     = p_q - LW'(3);

  // sequencer
  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    p_d       = p_q;
    ph_d      = ph_q;
    held_d    = held_q;
    stop_d    = stop_q;
    fin_d     = fin_q;
    wfin_d    = wfin_q;
    data_d    = data_q;
    qcnt_d    = qcnt_q;
    que_d     = que_q;
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = '0;
    ram_wdata = udn_pkg::ChSlash;
    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          data_d = '0;
          fin_d  = 1'b0;
          qcnt_d = '0;
          unique case (req_i.mode)
            udn_pkg::ModeByte: begin
              state_d = SNext;
              if (!stop_q) begin
                if (ph_q == 2'd1) begin
                  if (udn_pkg::is_hex(req_i.url_byte)) begin
                    held_d = req_i.url_byte;
                    ph_d   = 2'd2;
                  end else begin
                    que_d[0] = udn_pkg::ChPct;
                    if (req_i.url_byte == udn_pkg::ChPct) begin
                      qcnt_d = 2'd1;
                      ph_d   = 2'd1;
                    end else begin
                      que_d[1] = req_i.url_byte;
                      qcnt_d   = 2'd2;
                      ph_d     = 2'd0;
                    end
                  end
                end else if (ph_q == 2'd2) begin
                  if (udn_pkg::is_hex(req_i.url_byte)) begin
                    que_d[0] = {udn_pkg::hex_val(held_q), udn_pkg::hex_val(req_i.url_byte)};
                    qcnt_d   = 2'd1;
                    ph_d     = 2'd0;
                  end else begin
                    que_d[0] = udn_pkg::ChPct;
                    que_d[1] = held_q;
                    if (req_i.url_byte == udn_pkg::ChPct) begin
                      qcnt_d = 2'd2;
                      ph_d   = 2'd1;
                    end else begin
                      que_d[2] = req_i.url_byte;
                      qcnt_d   = 2'd3;
                      ph_d     = 2'd0;
                    end
                  end
                end else begin
                  if (req_i.url_byte == udn_pkg::ChPct) begin
                    ph_d = 2'd1;
                  end else begin
                    que_d[0] = req_i.url_byte;
                    qcnt_d   = 2'd1;
                  end
                end
              end
            end
            udn_pkg::ModeFinish: begin
              state_d  = SNext;
              fin_d    = 1'b1;
              que_d[0] = udn_pkg::ChPct;
              que_d[1] = held_q;
              qcnt_d   = ph_q;
              ph_d     = 2'd0;
            end
            udn_pkg::ModeRead: begin
              state_d  = SRd;
              ram_en   = 1'b1;
              ram_addr = req_i.read_index;
            end
            udn_pkg::ModeStart: begin
              state_d = SDone;
              ram_en  = 1'b1;
              ram_we  = 1'b1;
              wp_d    = LW'(1);
              ph_d    = 2'd0;
              held_d  = '0;
              stop_d  = 1'b0;
            end
            default: ;
          endcase
        end
      end
      SInit: begin
        ram_en  = 1'b1;
        ram_we  = 1'b1;
        state_d = SIdle;
      end
      SNext: begin
        if (qcnt_q == 2'd0) begin
          state_d = fin_q ? SF0 : SDone;
        end else begin
          que_d[0] = que_q[1];
          que_d[1] = que_q[2];
          qcnt_d   = qcnt_q - 2'd1;
          p_d      = wp_q;
          if (stop_q) begin
            state_d = SNext;
          end else if (wp_q >= cap_lim || wp_q == '0) begin
            stop_d = 1'b1;
          end else if (que_q[0] != udn_pkg::ChSlash) begin
            ram_en    = 1'b1;
            ram_we    = 1'b1;
            ram_addr  = wp_q[AW-1:0];
            ram_wdata = que_q[0];
            wp_d      = wp_q + LW'(1);
            if (wp_q + LW'(1) >= cap_lim) stop_d = 1'b1;
          end else begin
            ram_en   = 1'b1;
            ram_addr = AW'(wp_q - LW'(1));
            state_d  = SE1;
          end
        end
      end
      SE1: begin
        state_d = SEw;
        if (ram_rdata == udn_pkg::ChSlash) begin
          p_d = p_q - LW'(1);
        end else if (ram_rdata == udn_pkg::ChDot && p_q >= LW'(2)) begin
          ram_en   = 1'b1;
          ram_addr = AW'(p_q - LW'(2));
          state_d  = SE2;
        end
      end
      SE2: begin
        state_d = SEw;
        if (ram_rdata == udn_pkg::ChSlash) begin
          p_d = p_q - LW'(2);
        end else if (ram_rdata == udn_pkg::ChDot && p_q >= LW'(3)) begin
          ram_en   = 1'b1;
          ram_addr = pm3[AW-1:0];
          state_d  = SE3;
        end
      end
      SE3, SF3: begin
        if (state_q == SE3) state_d = SEw;
        else state_d = SDone;
        if (ram_rdata == udn_pkg::ChSlash) begin
          if (pm3 != '0) begin
            ram_en   = 1'b1;
            ram_addr = AW'(pm3 - LW'(1));
            p_d      = pm3 - LW'(1);
            wfin_d   = (state_q == SF3);
            state_d  = SWk;
          end else if (state_q == SE3) begin
            p_d = '0;
          end else begin
            wp_d = LW'(1);
          end
        end
      end
      SEw: begin
        ram_en   = 1'b1;
        ram_we   = 1'b1;
        ram_addr = p_q[AW-1:0];
        wp_d     = p_q + LW'(1);
        if (p_q + LW'(1) >= cap_lim) stop_d = 1'b1;
        state_d  = SNext;
      end
      SWk: begin
        if (p_q != '0 && ram_rdata != udn_pkg::ChSlash) begin
          ram_en   = 1'b1;
          ram_addr = AW'(p_q - LW'(1));
          p_d      = p_q - LW'(1);
        end else if (wfin_q) begin
          wp_d    = p_q + LW'(1);
          state_d = SDone;
        end else begin
          state_d = SEw;
        end
      end
      SF0: begin
        p_d     = wp_q;
        state_d = SDone;
        if (wp_q >= LW'(2) && wp_q <= udn_pkg::CapReset) begin
          ram_en   = 1'b1;
          ram_addr = AW'(wp_q - LW'(1));
          state_d  = SF1;
        end
      end
      SF1: begin
        state_d = SDone;
        if (ram_rdata == udn_pkg::ChDot) begin
          ram_en   = 1'b1;
          ram_addr = AW'(p_q - LW'(2));
          state_d  = SF2;
        end
      end
      SF2: begin
        state_d = SDone;
        if (ram_rdata == udn_pkg::ChSlash) begin
          wp_d = p_q - LW'(1);
        end else if (ram_rdata == udn_pkg::ChDot && p_q >= LW'(3)) begin
          ram_en   = 1'b1;
          ram_addr = pm3[AW-1:0];
          state_d  = SF3;
        end
      end
      SRd: begin
        data_d  = ram_rdata;
        state_d = SDone;
      end
      SDone: state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SInit;
      wp_q    <= LW'(1);
      ph_q    <= '0;
      held_q  <= '0;
      stop_q  <= 1'b0;
      fin_q   <= 1'b0;
      wfin_q  <= 1'b0;
      qcnt_q  <= '0;
      cap_q   <= udn_pkg::CapReset;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      ph_q    <= ph_d;
      held_q  <= held_d;
      stop_q  <= stop_d;
      fin_q   <= fin_d;
      wfin_q  <= wfin_d;
      qcnt_q  <= qcnt_d;
      if (cfg_we_i) cap_q <= cfg_wdata_i;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    p_q    <= p_d;
    data_q <= data_d;
    que_q  <= que_d;
  end

  // result
  assign busy_o            = (state_q != SIdle);
  assign done_o            = (state_q == SDone);
  assign rsp_o.path_length = wp_q;
  assign rsp_o.read_data   = data_q;
  assign rsp_o.stopped     = stop_q;

  a_accept_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("accepted request did not raise busy");
  a_wp_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> (wp_q != '0)) else $error("path length zero at idle");
  a_queue_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SIdle) |-> (qcnt_q == 2'd0)) else $error("emit queue not drained");
  a_stop_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(stop_q) |-> $past(busy_o)) else $error("stop set outside a request");

endmodule

>>> src/udn_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// udn_ram: single port synchronous ram
// One access a cycle, read data registered.
// ----------------------------------------------------------------------------
module udn_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024,
  localparam int AW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write or read one entry
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule
